// ===== hdl/tp_pkg.sv =====
// tp_pkg: shared types, constants and helper functions for the text to int64 parser
// used by the top level, tp_front and tp_back; depends on nothing
`timescale 1ns / 1ps

package tp_pkg;

  localparam int unsigned MAX_OFFSET_DEF = 1023;
  localparam int unsigned OFFSET_W       = 10;
  localparam int unsigned MAG_W          = 63;
  localparam int unsigned PROD_W         = 68;
  localparam int unsigned BASE_W         = 5;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned PADDR_W        = 3;

  localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;
  localparam logic [BASE_W-1:0] RADIX_RST = 5'd10;

  // register index of radix, decoded from the word address
  localparam logic REG_RADIX = 1'b0;

  typedef enum logic [4:0] {
    PH_SPACE  = 5'b00001,
    PH_SIGNED = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } tp_phase_t;

  // one classified character as it travels through the queue
  typedef struct packed {
    logic       start;
    logic       is_space;
    logic       is_minus;
    logic       is_sign;
    logic       is_zero;
    logic       is_x;
    logic       oct_ok;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] dval;
  } tp_item_t;

  function automatic logic tp_digit_ok(input tp_item_t it, input logic [BASE_W-1:0] b);
    logic ok;
    ok = 1'b0;
    case (b)
      BASE_HEX: ok = it.hex_ok;
      BASE_DEC: ok = it.dec_ok;
      BASE_OCT: ok = it.oct_ok;
      default:  ok = 1'b0;
    endcase
    return ok;
  endfunction

  // mag * base + digit, base is one of 8, 10, 16 here
  function automatic logic [PROD_W-1:0] tp_mul_add(input logic [MAG_W-1:0] mag,
                                                   input logic [BASE_W-1:0] b,
                                                   input logic [3:0] d);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] p;
    m = PROD_W'(mag);
    case (b)
      BASE_HEX: p = m << 4;
      BASE_OCT: p = m << 3;
      default:  p = (m << 3) + (m << 1);
    endcase
    return p + PROD_W'(d);
  endfunction

endpackage

// ===== hdl/text_to_int64_parser_saturating_unit.sv =====
// text_to_int64_parser_saturating_unit: top level, radix register and module wiring
// depends on tp_pkg, tp_front, tp_fifo and tp_back
`timescale 1ns / 1ps

// Streaming text to signed 64-bit integer parser.
// Input channel (in_valid/in_ready): one character per transaction on in_ch;
// in_start_req marks the first character of a new string and drops any
// unfinished one. Leading whitespace and one sign are skipped, digits are
// accumulated in the base given by the radix register (0 detects 0 / 0x).
// Output channel (out_valid/out_ready): one transaction per string, at the first
// non-digit character or at an overflowing digit, carrying the value, the offset
// of the stopping character and the overflow flag; the value saturates on
// overflow. Characters after the result are ignored until the next start request.
// A digit goes through the accumulator as a multiply-add, then a range check
// and commit; no new character leaves the queue until that digit is done.
// The result is registered: out_valid rises once the stopping character has
// left the queue or an overflowing digit has passed its range check, after any
// earlier digits have left the queue and the accumulator.
// A two-entry queue between classifier and accumulator keeps accepting while
// a result waits; once another result is due in a stall, the queue fills and in_ready drops.
// Reset (rst_n low, synchronous) empties the queue and result register, clears
// the parse state and sets radix to 10. Radix is written over the APB port.

module text_to_int64_parser_saturating_unit #(
  parameter int unsigned MAX_OFFSET = tp_pkg::MAX_OFFSET_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tp_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_ch,
  input  logic                            in_start_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [63:0]              out_value,
  output logic [tp_pkg::OFFSET_W-1:0]     out_end_offset,
  output logic                            out_overflowed
);

  import tp_pkg::*;

  localparam int unsigned ITEM_W = $bits(tp_item_t);

  logic [BASE_W-1:0] radix_r, radix_nxt;
  logic              reg_wr;
  tp_item_t          push_item, head_item;
  logic [ITEM_W-1:0] head_bits;
  logic              q_full, q_push, q_pop, q_not_empty;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);
  assign prdata = (paddr[2] == REG_RADIX) ? {27'd0, radix_r} : 32'd0;

  always_comb begin
    radix_nxt = radix_r;
    if (reg_wr) begin
      radix_nxt = pwdata[BASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RST;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  tp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .in_start_req (in_start_req),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  tp_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (head_bits),
    .not_empty (q_not_empty)
  );

  assign head_item = tp_item_t'(head_bits);

  tp_back #(
    .MAX_OFFSET (MAX_OFFSET)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .radix          (radix_r),
    .hd             (head_item),
    .hd_valid       (q_not_empty),
    .hd_pop         (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_end_offset (out_end_offset),
    .out_overflowed (out_overflowed)
  );

endmodule

// ===== hdl/tp_fifo.sv =====
// tp_fifo: small register queue between the classifier and the accumulator
// generic width and depth; no package dependency
`timescale 1ns / 1ps

module tp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hdl/tp_front.sv =====
// tp_front: input side, takes characters and classifies them for the accumulator
// depends on tp_pkg for the item type
`timescale 1ns / 1ps

module tp_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_ch,
  input  logic              in_start_req,
  input  logic              q_full,
  output logic              q_push,
  output tp_pkg::tp_item_t  q_item
);

  import tp_pkg::*;

  logic is_09, is_af, is_uaf;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign is_09  = (in_ch >= 8'h30) && (in_ch <= 8'h39);
  assign is_af  = (in_ch >= 8'h61) && (in_ch <= 8'h66);
  assign is_uaf = (in_ch >= 8'h41) && (in_ch <= 8'h46);

  always_comb begin
    q_item.start    = in_start_req;
    // space, tab, lf, vt, ff, cr
    q_item.is_space = (in_ch == 8'h20) || ((in_ch >= 8'h09) && (in_ch <= 8'h0d));
    q_item.is_minus = (in_ch == 8'h2d);
    q_item.is_sign  = (in_ch == 8'h2d) || (in_ch == 8'h2b);
    q_item.is_zero  = (in_ch == 8'h30);
    q_item.is_x     = (in_ch == 8'h78) || (in_ch == 8'h58);
    q_item.oct_ok   = (in_ch >= 8'h30) && (in_ch <= 8'h37);
    q_item.dec_ok   = is_09;
    q_item.hex_ok   = is_09 || is_af || is_uaf;
    if (is_09) begin
      q_item.dval = in_ch[3:0];
    end else begin
      // letters a..f and A..F share the low three bits
      q_item.dval = 4'd9 + {1'b0, in_ch[2:0]};
    end
  end

endmodule

// ===== hdl/tp_back.sv =====
// tp_back: parse state machine, multiply-add accumulator and result register
// depends on tp_pkg for the phase enum, item type and arithmetic helpers
`timescale 1ns / 1ps

module tp_back #(
  parameter int unsigned MAX_OFFSET = tp_pkg::MAX_OFFSET_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tp_pkg::BASE_W-1:0]     radix,
  input  tp_pkg::tp_item_t              hd,
  input  logic                          hd_valid,
  output logic                          hd_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [63:0]            out_value,
  output logic [tp_pkg::OFFSET_W-1:0]   out_end_offset,
  output logic                          out_overflowed
);

  import tp_pkg::*;

  localparam int unsigned OFFSET_CAP = (MAX_OFFSET < 1023) ? MAX_OFFSET : 1023;
  localparam logic [OFFSET_W-1:0] CAP = OFFSET_W'(OFFSET_CAP);

  tp_phase_t           phase_r, phase_nxt, eff_phase, step_phase;
  logic                neg_r, neg_nxt, eff_neg, step_neg;
  logic [BASE_W-1:0]   base_r, base_nxt, eff_base, step_base;
  logic [MAG_W-1:0]    mag_r, mag_nxt, eff_mag;
  logic [OFFSET_W-1:0] cnt_r, cnt_nxt, eff_cnt, step_cnt;
  logic                mul_r, mul_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic                take_pre, try_dig, need_emit, need_mul, out_free, prod_ovf;
  logic                out_valid_r, out_valid_nxt;
  logic [63:0]         val_r, val_nxt;
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic                ovf_r, ovf_nxt;

  function automatic logic [OFFSET_W-1:0] inc_cnt(input logic [OFFSET_W-1:0] c);
    return (c < CAP) ? c + 1'b1 : c;
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign prod_ovf = (prod_r[PROD_W-1:MAG_W] != '0);

  // a start request clears the string state before the character is handled
  always_comb begin
    if (hd.start) begin
      eff_phase = PH_SPACE;
      eff_neg   = 1'b0;
      eff_base  = '0;
      eff_mag   = '0;
      eff_cnt   = '0;
    end else begin
      eff_phase = phase_r;
      eff_neg   = neg_r;
      eff_base  = base_r;
      eff_mag   = mag_r;
      eff_cnt   = cnt_r;
    end
  end

  // classify what the head character does in the current phase
  always_comb begin
    take_pre   = 1'b0;
    try_dig    = 1'b0;
    step_phase = eff_phase;
    step_neg   = eff_neg;
    step_base  = eff_base;
    step_cnt   = eff_cnt;
    unique case (eff_phase)
      PH_SPACE: begin
        if (hd.is_space) begin
          step_cnt = inc_cnt(eff_cnt);
        end else if (hd.is_sign) begin
          step_neg   = hd.is_minus;
          step_cnt   = inc_cnt(eff_cnt);
          step_phase = PH_SIGNED;
        end else begin
          take_pre = 1'b1;
        end
      end
      PH_SIGNED: take_pre = 1'b1;
      PH_ZERO: begin
        if (hd.is_x) begin
          step_base  = BASE_HEX;
          step_cnt   = inc_cnt(eff_cnt);
          step_phase = PH_DIGITS;
        end else begin
          try_dig = 1'b1;
        end
      end
      PH_DIGITS: try_dig = 1'b1;
      PH_DONE: ;
      default: ;
    endcase
    if (take_pre) begin
      if (radix == BASE_AUTO) begin
        if (hd.is_zero) begin
          step_base  = BASE_OCT;
          step_cnt   = inc_cnt(eff_cnt);
          step_phase = PH_ZERO;
        end else begin
          step_base = BASE_DEC;
          try_dig   = 1'b1;
        end
      end else begin
        step_base = radix;
        try_dig   = 1'b1;
      end
    end
    need_mul  = try_dig && tp_digit_ok(hd, step_base);
    need_emit = try_dig && !need_mul;
  end

  assign hd_pop = !mul_r && hd_valid && (!need_emit || out_free);

  always_comb begin
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    mag_nxt       = mag_r;
    cnt_nxt       = cnt_r;
    mul_nxt       = mul_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    val_nxt       = val_r;
    off_nxt       = off_r;
    ovf_nxt       = ovf_r;
    if (mul_r) begin
      // range check of a digit after its multiply-add: commit, or saturate once the output is free
      if (prod_ovf) begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          val_nxt       = neg_r ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
          off_nxt       = cnt_r;
          ovf_nxt       = 1'b1;
          phase_nxt     = PH_DONE;
          mul_nxt       = 1'b0;
        end
      end else begin
        mag_nxt   = prod_r[MAG_W-1:0];
        cnt_nxt   = inc_cnt(cnt_r);
        phase_nxt = PH_DIGITS;
        mul_nxt   = 1'b0;
      end
    end else if (hd_pop) begin
      phase_nxt = step_phase;
      neg_nxt   = step_neg;
      base_nxt  = step_base;
      mag_nxt   = eff_mag;
      cnt_nxt   = step_cnt;
      if (need_emit) begin
        out_valid_nxt = 1'b1;
        val_nxt       = step_neg ? 64'd0 - {1'b0, eff_mag} : {1'b0, eff_mag};
        off_nxt       = step_cnt;
        ovf_nxt       = 1'b0;
        phase_nxt     = PH_DONE;
      end else if (need_mul) begin
        mul_nxt  = 1'b1;
        prod_nxt = tp_mul_add(eff_mag, step_base, hd.dval);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SPACE;
      neg_r       <= 1'b0;
      base_r      <= '0;
      mag_r       <= '0;
      cnt_r       <= '0;
      mul_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      base_r      <= base_nxt;
      mag_r       <= mag_nxt;
      cnt_r       <= cnt_nxt;
      mul_r       <= mul_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    val_r  <= val_nxt;
    off_r  <= off_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_value      = val_r;
  assign out_end_offset = off_r;
  assign out_overflowed = ovf_r;

endmodule
